@@ rtl/csc_pkg.sv @@
`default_nettype none
package csc_pkg;

  // angle constants in Q16.16 degrees, wide enough for the wrapped range
  localparam logic signed [25:0] DEG360 = 26'sd23592960;
  localparam logic signed [25:0] DEG180 = 26'sd11796480;
  localparam logic signed [25:0] DEG90  = 26'sd5898240;

  // 360 degrees = 45 * 2^19; the high part of the angle is reduced mod 45
  localparam int          DEG_LOW_BITS = 19;
  localparam logic [13:0] DEG_MOD      = 14'd45;
  localparam logic [13:0] HI_OFFSET    = 14'd4140;   // 92 * 45, makes the high part positive

  localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] RAD_Q44 = ((PI_Q62 / 64'd180) + (64'd1 << 17)) >> 18;

  // pi/180 split so that each partial product fits the 32x32 multiplier
  localparam int          RAD_SPLIT = 20;
  localparam logic [31:0] RAD_LO    = 32'(RAD_Q44 & ((64'd1 << RAD_SPLIT) - 64'd1));
  localparam logic [31:0] RAD_HI    = 32'(RAD_Q44 >> RAD_SPLIT);

  localparam logic [31:0] GAIN_Q32  = 32'd2608131496;
  localparam logic [30:0] OUT_LIMIT = 31'h40000000;

  // shift-subtract quotient, evaluated at elaboration only
  function automatic logic [63:0] long_quot(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in unsigned Q62 from the truncated odd series
  function automatic logic [63:0] atan_q62(int i);
    logic [63:0] pos;
    logic [63:0] negs;
    logic [63:0] t;
    int          e;
    pos  = '0;
    negs = '0;
    if (i == 0) begin
      return PI4_Q62;
    end
    for (int k = 0; (k < 32) && (i * (2 * k + 1) <= 62); k++) begin
      e = 62 - i * (2 * k + 1);
      t = long_quot(64'd1 << e, 64'(2 * k + 1));
      if (k % 2 == 1) negs = negs + t;
      else            pos  = pos + t;
    end
    return pos - negs;
  endfunction

endpackage
`default_nettype wire

@@ rtl/csc_rotator.sv @@
`default_nettype none
// One rotation-mode micro-rotation: shift-add on x/y, arctangent step on z.
module csc_rotator #(
  parameter int ITERATIONS     = 40,
  parameter int INTERNAL_WIDTH = 64,
  parameter int IW             = $clog2(ITERATIONS)
) (
  input  wire logic [INTERNAL_WIDTH-1:0] x_i,
  input  wire logic [INTERNAL_WIDTH-1:0] y_i,
  input  wire logic [INTERNAL_WIDTH-1:0] z_i,
  input  wire logic [IW-1:0]             iter_i,
  output logic      [INTERNAL_WIDTH-1:0] x_o,
  output logic      [INTERNAL_WIDTH-1:0] y_o,
  output logic      [INTERNAL_WIDTH-1:0] z_o
);
  import csc_pkg::*;

  localparam int W       = INTERNAL_WIDTH;
  localparam int RND_SH  = 65 - W;   // Q62 down to W-3 fraction bits

  function automatic logic [ITERATIONS-1:0][W-1:0] build_rom();
    logic [ITERATIONS-1:0][W-1:0] rom;
    logic [64:0]                  v;
    for (int i = 0; i < ITERATIONS; i++) begin
      v      = ({1'b0, atan_q62(i)} + (65'd1 << (RND_SH - 1))) >> RND_SH;
      rom[i] = v[W-1:0];
    end
    return rom;
  endfunction

  localparam logic [ITERATIONS-1:0][W-1:0] ATAN_ROM = build_rom();

  logic [W-1:0] xs;
  logic [W-1:0] ys;
  logic [W-1:0] step;

  // shifts past the width fill with the sign bit
  assign xs   = W'($signed(x_i) >>> iter_i);
  assign ys   = W'($signed(y_i) >>> iter_i);
  assign step = ATAN_ROM[iter_i];

  always_comb begin
    if (!z_i[W-1]) begin
      x_o = x_i - ys;
      y_o = y_i + xs;
      z_o = z_i - step;
    end else begin
      x_o = x_i + ys;
      y_o = y_i - xs;
      z_o = z_i + step;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cordic_sine_cosine_unit.sv @@
`default_nettype none
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+---------------------------
// input    | in_angle_degrees                                   | start & !busy
// result   | out_sine_value, out_cosine_value, out_angle_mirrored | out_strobe, one cycle
//
// A word is accepted only while idle, so the next accept waits for the result;
// the micro-rotation loop runs one rotator per cycle.
// Ahead of the loop: wrap, fold, two partial products for degrees to radians.
// After it: magnitude, rounding, two gain products on the shared multiplier.
// busy is high from the accept until the result is registered; the strobe
// cycle already accepts the next word; the receiver never stalls. rst_n: sync, active low.
module cordic_sine_cosine_unit #(
  parameter int ITERATIONS     = 40,
  parameter int INTERNAL_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] in_angle_degrees,
  output logic                    busy,
  output logic                    out_strobe,
  output logic signed [31:0]      out_sine_value,
  output logic signed [31:0]      out_cosine_value,
  output logic                    out_angle_mirrored
);
  import csc_pkg::*;

  localparam int W    = INTERNAL_WIDTH;
  localparam int FRAC = W - 3;
  localparam int IW   = $clog2(ITERATIONS);

  // radians product is Q60
  localparam int          ZL    = (FRAC >= 60) ? FRAC - 60 : 0;
  localparam int          ZR    = (FRAC >= 60) ? 0 : 60 - FRAC;
  localparam logic [63:0] ZHALF = (ZR > 0) ? (64'd1 << ((ZR > 0) ? ZR - 1 : 0)) : 64'd0;
  // output magnitude goes to Q31 before the gain
  localparam int          SR     = (FRAC >= 31) ? FRAC - 31 : 0;
  localparam int          SL     = (FRAC >= 31) ? 0 : 31 - FRAC;
  localparam logic [65:0] HALF31 = (SR > 0) ? (66'd1 << ((SR > 0) ? SR - 1 : 0)) : 66'd0;

  localparam logic [IW-1:0] LAST_ITER = IW'(ITERATIONS - 1);
  localparam logic [IW-1:0] ITER_ONE  = IW'(1);
  localparam logic [W-1:0]  X_INIT    = W'(1) << FRAC;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_FOLD  = 4'd2;
  localparam logic [3:0] S_RAD0  = 4'd3;
  localparam logic [3:0] S_RAD1  = 4'd4;
  localparam logic [3:0] S_RAD2  = 4'd5;
  localparam logic [3:0] S_ZINIT = 4'd6;
  localparam logic [3:0] S_ITER  = 4'd7;
  localparam logic [3:0] S_MAG   = 4'd8;
  localparam logic [3:0] S_RND   = 4'd9;
  localparam logic [3:0] S_MULY  = 4'd10;
  localparam logic [3:0] S_MULX  = 4'd11;
  localparam logic [3:0] S_FINX  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  // wrap into (-180,180]: low 19 bits pass, the high part is reduced mod 45
  function automatic logic signed [25:0] wrap_angle(logic [31:0] a);
    logic [13:0]        hu;
    logic [13:0]        step;
    logic signed [25:0] r;
    hu = {a[31], a[31:DEG_LOW_BITS]} + HI_OFFSET;
    for (int k = 7; k >= 0; k--) begin
      step = DEG_MOD << k;
      if (hu >= step) hu = hu - step;
    end
    r = $signed({1'b0, hu[5:0], a[DEG_LOW_BITS-1:0]});
    if (r > DEG180) r = r - DEG360;
    return r;
  endfunction

  function automatic logic [31:0] round_q31(logic [W-1:0] m);
    logic [65:0] t;
    t = (({{(66 - W){1'b0}}, m} + HALF31) >> SR) << SL;
    if (t > 66'hFFFFFFFF) return 32'hFFFFFFFF;
    return t[31:0];
  endfunction

  function automatic logic [30:0] gain_round(logic [63:0] p);
    logic [64:0] t;
    t = ({1'b0, p} + (65'd1 << 32)) >> 33;
    if (t[30:0] > OUT_LIMIT) return OUT_LIMIT;
    return t[30:0];
  endfunction

  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic [31:0]        ang_r;
  logic signed [25:0] rs_r;
  logic [22:0]        m_r;
  logic               zneg_r;
  logic               mir_r;
  logic [63:0]        mul_r;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        acc_r;
  logic [W-1:0]       x_r;
  logic [W-1:0]       y_r;
  logic [W-1:0]       z_r;
  logic [W-1:0]       x_nxt;
  logic [W-1:0]       y_nxt;
  logic [W-1:0]       z_nxt;
  logic [IW-1:0]      iter_r;
  logic               xneg_r;
  logic               yneg_r;
  logic [W-1:0]       mx_r;
  logic [W-1:0]       my_r;
  logic [31:0]        mx31_r;
  logic [31:0]        my31_r;
  logic [30:0]        ry_r;
  logic [30:0]        rx_r;
  logic signed [25:0] fold;
  logic               fold_mir;
  logic [W-1:0]       zm;
  logic [31:0]        ry_ext;
  logic [31:0]        rx_ext;

  csc_rotator #(
    .ITERATIONS     (ITERATIONS),
    .INTERNAL_WIDTH (INTERNAL_WIDTH),
    .IW             (IW)
  ) u_rotator (
    .x_i    (x_r),
    .y_i    (y_r),
    .z_i    (z_r),
    .iter_i (iter_r),
    .x_o    (x_nxt),
    .y_o    (y_nxt),
    .z_o    (z_nxt)
  );

  assign busy = (state_r != S_IDLE);

  // mirror about +/-90; exactly +/-90 stays
  always_comb begin
    fold     = rs_r;
    fold_mir = 1'b0;
    if (rs_r > DEG90) begin
      fold     = DEG180 - rs_r;
      fold_mir = 1'b1;
    end else if (rs_r < -DEG90) begin
      fold     = -DEG180 - rs_r;
      fold_mir = 1'b1;
    end
  end

  assign zm = W'((acc_r >> ZR) << ZL);

  always_comb begin
    unique case (state_r)
      S_RAD0:  begin mul_a = {9'd0, m_r}; mul_b = RAD_LO;   end
      S_RAD1:  begin mul_a = {9'd0, m_r}; mul_b = RAD_HI;   end
      S_MULY:  begin mul_a = my31_r;      mul_b = GAIN_Q32; end
      S_MULX:  begin mul_a = mx31_r;      mul_b = GAIN_Q32; end
      default: begin mul_a = '0;          mul_b = '0;       end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_WRAP;
      S_WRAP:  state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_RAD0;
      S_RAD0:  state_nxt = S_RAD1;
      S_RAD1:  state_nxt = S_RAD2;
      S_RAD2:  state_nxt = S_ZINIT;
      S_ZINIT: state_nxt = S_ITER;
      S_ITER:  if (iter_r == LAST_ITER) state_nxt = S_MAG;
      S_MAG:   state_nxt = S_RND;
      S_RND:   state_nxt = S_MULY;
      S_MULY:  state_nxt = S_MULX;
      S_MULX:  state_nxt = S_FINX;
      S_FINX:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == S_OUT);
    end
  end

  assign ry_ext = {1'b0, ry_r};
  assign rx_ext = {1'b0, rx_r};

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE:  if (start) ang_r <= in_angle_degrees;
      S_WRAP:  rs_r <= wrap_angle(ang_r);
      S_FOLD: begin
        mir_r  <= fold_mir;
        zneg_r <= fold[25];
        m_r    <= fold[25] ? 23'(-fold) : fold[22:0];
      end
      S_RAD0:  ;
      S_RAD1:  acc_r <= mul_r + ZHALF;
      S_RAD2:  acc_r <= acc_r + (mul_r << RAD_SPLIT);
      S_ZINIT: begin
        z_r    <= zneg_r ? -zm : zm;
        x_r    <= X_INIT;
        y_r    <= '0;
        iter_r <= '0;
      end
      S_ITER: begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        iter_r <= iter_r + ITER_ONE;
      end
      S_MAG: begin
        xneg_r <= x_r[W-1];
        yneg_r <= y_r[W-1];
        mx_r   <= x_r[W-1] ? -x_r : x_r;
        my_r   <= y_r[W-1] ? -y_r : y_r;
      end
      S_RND: begin
        mx31_r <= round_q31(mx_r);
        my31_r <= round_q31(my_r);
      end
      S_MULY:  ;
      S_MULX:  ry_r <= gain_round(mul_r);
      S_FINX:  rx_r <= gain_round(mul_r);
      S_OUT: begin
        // mirror negation folds into the sign of x; a zero stays zero
        out_sine_value     <= yneg_r ? -$signed(ry_ext) : $signed(ry_ext);
        out_cosine_value   <= (xneg_r ^ mir_r) ? -$signed(rx_ext) : $signed(rx_ext);
        out_angle_mirrored <= mir_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
